// ----- sv/nhsr_pkg.sv -----
// ----------------------------------------------------------------------------
// nhsr_pkg
// Kinds, status codes and shared types of the next-hop success ranker.
// ----------------------------------------------------------------------------
package nhsr_pkg;

  localparam logic [2:0] KIND_QUERY   = 3'd0;
  localparam logic [2:0] KIND_SUCCESS = 3'd1;
  localparam logic [2:0] KIND_FAILURE = 3'd2;
  localparam logic [2:0] KIND_RESET   = 3'd3;
  localparam logic [2:0] KIND_ADD     = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // compare request from sequencer to comparator
  typedef struct packed {
    logic [31:0] sa;
    logic [31:0] fa;
    logic [31:0] ta;
    logic [31:0] sb;
    logic [31:0] fb;
    logic [31:0] tb;
  } cmp_req_t;

endpackage

// ----- sv/nhsr_cmp.sv -----
// ----------------------------------------------------------------------------
// nhsr_cmp
// Shared rank comparator: cross-multiplied ratio, then time.
// ----------------------------------------------------------------------------
module nhsr_cmp #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  nhsr_pkg::cmp_req_t req_i,
  output logic              above_o
);
  import nhsr_pkg::*;

  logic [2*COUNT_BITS-1:0] l_q, r_q;
  logic                    tgt_q;
  logic [COUNT_BITS-1:0]   sa, sb, fa, fb;

  always_comb begin
    sa = req_i.sa[COUNT_BITS-1:0];
    sb = req_i.sb[COUNT_BITS-1:0];
    fa = (req_i.sa == '0 && req_i.fa == '0) ? COUNT_BITS'(1) : req_i.fa[COUNT_BITS-1:0];
    fb = (req_i.sb == '0 && req_i.fb == '0) ? COUNT_BITS'(1) : req_i.fb[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    l_q   <= sa * fb;
    r_q   <= sb * fa;
    tgt_q <= req_i.ta > req_i.tb;
  end

  assign above_o = (l_q != r_q) ? (l_q > r_q) : tgt_q;

endmodule

// ----- sv/next_hop_success_ranker_unit.sv -----
// ----------------------------------------------------------------------------
// next_hop_success_ranker_unit
// Per-destination next-hop table with saturating counts and ranked lists.
// ----------------------------------------------------------------------------
// Sequence: tag search; for queries and records a gather of the hop slots; for records
//   a prep step, insertion sort on the shared comparator and write-back of the hop
//   slots; then the output register.
// One request at a time: the input stalls until the answer goes to the output register.
// Reset: asynchronous; clears all valid bits and the sequencer, no sweep.
module next_hop_success_ranker_unit #(
  parameter int DEST_ENTRIES  = 16,
  parameter int HOPS_PER_DEST = 4,
  parameter int COUNT_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] dest_i,
  input  logic [7:0]  hop_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        has_choice_o,
  output logic [7:0]  next_hop_o,
  output logic [1:0]  status_o
);
  import nhsr_pkg::*;

  localparam int DW = (DEST_ENTRIES > 1) ? $clog2(DEST_ENTRIES) : 1;
  localparam int CT = DEST_ENTRIES * HOPS_PER_DEST;
  localparam int CW = (CT > 1) ? $clog2(CT) : 1;
  localparam int LN = HOPS_PER_DEST + 1;
  localparam int LW = $clog2(LN + 1);
  localparam int HW = (HOPS_PER_DEST > 1) ? $clog2(HOPS_PER_DEST) : 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  localparam logic [3:0] S_IDLE = 4'd0, S_SRCH = 4'd1, S_GATH = 4'd2,
                         S_RDW = 4'd3, S_PREP = 4'd4, S_SORT = 4'd5,
                         S_CMPW = 4'd6, S_CMPR = 4'd7, S_WB = 4'd8,
                         S_OUT = 4'd9, S_GRD = 4'd10;

  logic [3:0] state_q;
  logic [2:0] kind_q;
  logic [31:0] dest_q, now_q;
  logic [7:0] hop_q;

  logic [31:0] dest_tag_q [DEST_ENTRIES];
  logic [DEST_ENTRIES-1:0] dest_valid_q;
  logic [CT-1:0] cand_valid_q;
  logic [7:0]            hop_m  [CT];
  logic [COUNT_BITS-1:0] s_m    [CT];
  logic [COUNT_BITS-1:0] f_m    [CT];
  logic [31:0]           t_m    [CT];
  logic [7:0]            hop_rd;
  logic [COUNT_BITS-1:0] s_rd, f_rd;
  logic [31:0]           t_rd;

  logic [7:0]            l_hop [LN];
  logic [COUNT_BITS-1:0] l_s   [LN];
  logic [COUNT_BITS-1:0] l_f   [LN];
  logic [31:0]           l_t   [LN];

  logic [DW:0] di_q;
  logic [DW-1:0] dsel_q;
  logic found_q, free_q;
  logic [DW-1:0] free_idx_q;
  logic [HW:0] k_q;
  logic [LW-1:0] n_q, i_q, j_q, at_q;
  logic [7:0]  x_hop_q;
  logic [COUNT_BITS-1:0] x_s_q, x_f_q;
  logic [31:0] x_t_q;
  logic has_q;
  logic [7:0] nh_q;
  logic [1:0] st_q;
  logic ov_q;
  logic out_has_q;
  logic [7:0] out_nh_q;
  logic [1:0] out_st_q;
  logic out_load;

  cmp_req_t creq;
  logic above;
  logic [CW-1:0] raddr;
  logic wr_en;
  logic [CW-1:0] waddr;

  nhsr_cmp #(.COUNT_BITS(COUNT_BITS)) u_cmp (
    .clk_i(clk_i), .req_i(creq), .above_o(above)
  );

  always_comb begin
    creq.sa = 32'(x_s_q);
    creq.fa = 32'(x_f_q);
    creq.ta = x_t_q;
    creq.sb = 32'(l_s[j_q - LW'(1)]);
    creq.fb = 32'(l_f[j_q - LW'(1)]);
    creq.tb = l_t[j_q - LW'(1)];
  end

  assign raddr = CW'(CT'(dsel_q) * HOPS_PER_DEST + 32'(k_q[HW-1:0]));
  assign waddr = raddr;
  assign wr_en = (state_q == S_WB) && (32'(k_q) < HOPS_PER_DEST) &&
                 (32'(k_q) < 32'(n_q));

  always_ff @(posedge clk_i) begin
    hop_rd <= hop_m[raddr];
    s_rd   <= s_m[raddr];
    f_rd   <= f_m[raddr];
    t_rd   <= t_m[raddr];
    if (wr_en) begin
      hop_m[waddr] <= l_hop[k_q[HW-1:0]];
      s_m[waddr]   <= l_s[k_q[HW-1:0]];
      f_m[waddr]   <= l_f[k_q[HW-1:0]];
      t_m[waddr]   <= l_t[k_q[HW-1:0]];
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = ov_q;
  assign has_choice_o = out_has_q;
  assign next_hop_o   = out_nh_q;
  assign status_o     = out_st_q;

  // answer held here so the sequencer may take the next request
  assign out_load = (state_q == S_OUT) && (!ov_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q      <= 1'b0;
      out_has_q <= 1'b0;
      out_nh_q  <= '0;
      out_st_q  <= ST_OK;
    end else if (out_load) begin
      ov_q      <= 1'b1;
      out_has_q <= has_q;
      out_nh_q  <= nh_q;
      out_st_q  <= st_q;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  logic is_rec;
  assign is_rec = (kind_q == KIND_SUCCESS) || (kind_q == KIND_FAILURE) ||
                  (kind_q == KIND_ADD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dest_valid_q <= '0;
      cand_valid_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q <= kind_i; dest_q <= dest_i; hop_q <= hop_i; now_q <= time_ms_i;
            di_q <= '0; found_q <= 1'b0; free_q <= 1'b0;
            has_q <= 1'b0; nh_q <= '0; st_q <= ST_OK;
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (32'(di_q) < DEST_ENTRIES && !found_q) begin
            if (dest_valid_q[di_q[DW-1:0]] && dest_tag_q[di_q[DW-1:0]] == dest_q) begin
              found_q <= 1'b1; dsel_q <= di_q[DW-1:0];
            end else if (!dest_valid_q[di_q[DW-1:0]] && !free_q) begin
              free_q <= 1'b1; free_idx_q <= di_q[DW-1:0];
            end
            di_q <= di_q + 1'b1;
          end else begin
            k_q <= '0; n_q <= '0; at_q <= LW'(LN);
            if (kind_q == KIND_QUERY) begin
              if (found_q) state_q <= S_RDW;
              else begin
                st_q <= ST_UNKNOWN; state_q <= S_OUT;
              end
            end else if (kind_q == KIND_RESET) begin
              state_q <= S_OUT;
              if (found_q) begin
                dest_valid_q[dsel_q] <= 1'b0;
                for (int k = 0; k < HOPS_PER_DEST; k++)
                  cand_valid_q[CW'(CT'(dsel_q) * HOPS_PER_DEST + k)] <= 1'b0;
              end else st_q <= ST_UNKNOWN;
            end else if (is_rec) begin
              if (found_q) state_q <= S_RDW;
              else if (free_q) begin
                dsel_q <= free_idx_q;
                dest_valid_q[free_idx_q] <= 1'b1;
                dest_tag_q[free_idx_q] <= dest_q;
                for (int k = 0; k < HOPS_PER_DEST; k++)
                  cand_valid_q[CW'(CT'(free_idx_q) * HOPS_PER_DEST + k)] <= 1'b0;
                state_q <= S_RDW;
              end else begin
                st_q <= ST_FULL; state_q <= S_OUT;
              end
            end else state_q <= S_OUT;
          end
        end
        S_RDW: state_q <= S_GATH;
        S_GATH: begin
          if (cand_valid_q[raddr]) begin
            l_hop[n_q] <= hop_rd; l_s[n_q] <= s_rd; l_f[n_q] <= f_rd; l_t[n_q] <= t_rd;
            n_q <= n_q + 1'b1;
            if (hop_rd == hop_q && at_q == LW'(LN)) at_q <= n_q;
            if (kind_q == KIND_QUERY && hop_rd != hop_q && s_rd != '0 && !has_q) begin
              has_q <= 1'b1; nh_q <= hop_rd;
            end
          end
          if (32'(k_q) == HOPS_PER_DEST - 1) begin
            state_q <= (kind_q == KIND_QUERY) ? S_GRD : S_PREP;
          end else begin
            k_q <= k_q + 1'b1; state_q <= S_RDW;
          end
        end
        S_GRD: begin
          if (n_q == '0) st_q <= ST_UNKNOWN;
          state_q <= S_OUT;
        end
        S_PREP: begin
          i_q <= LW'(1);
          if (kind_q == KIND_ADD) begin
            if (at_q == LW'(LN)) begin
              l_hop[n_q] <= hop_q; l_s[n_q] <= '0; l_f[n_q] <= '0; l_t[n_q] <= '0;
              n_q <= n_q + 1'b1;
              state_q <= S_SORT;
            end else state_q <= S_OUT;
          end else begin
            state_q <= S_SORT;
            if (at_q == LW'(LN)) begin
              l_hop[n_q] <= hop_q; l_t[n_q] <= now_q;
              l_s[n_q] <= (kind_q == KIND_SUCCESS) ? COUNT_BITS'(1) : '0;
              l_f[n_q] <= (kind_q == KIND_FAILURE) ? COUNT_BITS'(1) : '0;
              n_q <= n_q + 1'b1;
            end else begin
              l_t[at_q] <= now_q;
              if (kind_q == KIND_SUCCESS && l_s[at_q] != CMAX) l_s[at_q] <= l_s[at_q] + 1'b1;
              if (kind_q == KIND_FAILURE && l_f[at_q] != CMAX) l_f[at_q] <= l_f[at_q] + 1'b1;
            end
          end
        end
        S_SORT: begin
          if (i_q < n_q) begin
            x_hop_q <= l_hop[i_q]; x_s_q <= l_s[i_q]; x_f_q <= l_f[i_q]; x_t_q <= l_t[i_q];
            j_q <= i_q; state_q <= S_CMPW;
          end else begin
            k_q <= '0; state_q <= S_WB;
          end
        end
        S_CMPW: begin
          if (j_q == '0) begin
            l_hop[j_q] <= x_hop_q; l_s[j_q] <= x_s_q; l_f[j_q] <= x_f_q; l_t[j_q] <= x_t_q;
            i_q <= i_q + 1'b1; state_q <= S_SORT;
          end else state_q <= S_CMPR;
        end
        S_CMPR: begin
          if (above) begin
            l_hop[j_q] <= l_hop[j_q-LW'(1)]; l_s[j_q] <= l_s[j_q-LW'(1)];
            l_f[j_q] <= l_f[j_q-LW'(1)]; l_t[j_q] <= l_t[j_q-LW'(1)];
            j_q <= j_q - 1'b1; state_q <= S_CMPW;
          end else begin
            l_hop[j_q] <= x_hop_q; l_s[j_q] <= x_s_q; l_f[j_q] <= x_f_q; l_t[j_q] <= x_t_q;
            i_q <= i_q + 1'b1; state_q <= S_SORT;
          end
        end
        S_WB: begin
          cand_valid_q[raddr] <= (32'(k_q) < 32'(n_q));
          if (32'(k_q) == HOPS_PER_DEST - 1) state_q <= S_OUT;
          else k_q <= k_q + 1'b1;
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("request taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_choice_o) |-> (status_o == ST_OK))
    else $error("choice with bad status");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_choice_o) |-> (next_hop_o == '0))
    else $error("hop without choice");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the next-hop success ranker: a queue-fed driver,
// a monitor comparing each answer against an in-bench model of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import nhsr_pkg::*;

  localparam int NDEST = 16;
  localparam int NHOP  = 4;
  localparam int NCAND = NDEST * NHOP;
  localparam logic [31:0] CMAX = 32'hFFFF;
  localparam int LIMIT = 400000;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] dest;
    logic [7:0]  hop;
    logic [31:0] tms;
  } req_t;

  typedef struct {
    logic       has;
    logic [7:0] nh;
    logic [1:0] st;
  } ans_t;

  typedef struct {
    logic [7:0]  hop;
    logic [31:0] s;
    logic [31:0] f;
    logic [31:0] t;
  } cand_t;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 0;
  logic [2:0] kind_i = 0;
  logic [31:0] dest_i = 0, time_ms_i = 0;
  logic [7:0] hop_i = 0;
  logic in_stall_o, out_valid_o, has_choice_o;
  logic [7:0] next_hop_o;
  logic [1:0] status_o;

  req_t pending_q[$];
  ans_t answer_q[$];
  int errors = 0, n_answers = 0, n_found = 0, cycles = 0;
  bit quiet = 0, hold_rx = 0, pause_tx = 0;
  bit in_taken = 0;

  logic [31:0] tag_m[NDEST];
  bit dvalid_m[NDEST];
  bit cvalid_m[NCAND];
  cand_t cand_m[NCAND];

  always #5 clk_i = ~clk_i;

  next_hop_success_ranker_unit i_dut (.*);

  function automatic bit outranks(cand_t a, cand_t b);
    logic [63:0] fa, fb, l, r;
    fa = (a.s == 0 && a.f == 0) ? 64'd1 : 64'(a.f);
    fb = (b.s == 0 && b.f == 0) ? 64'd1 : 64'(b.f);
    l = 64'(a.s) * fb;
    r = 64'(b.s) * fa;
    if (l != r) return l > r;
    return a.t > b.t;
  endfunction

  function automatic int lookup_dest(logic [31:0] dest);
    for (int d = 0; d < NDEST; d++)
      if (dvalid_m[d] && tag_m[d] == dest) return d;
    return -1;
  endfunction

  function automatic ans_t table_apply(req_t r);
    ans_t a;
    cand_t lst[NHOP+1];
    cand_t x;
    int d, n, at, j;
    a = '{1'b0, 8'd0, ST_OK};
    n = 0;
    d = lookup_dest(r.dest);
    if (d >= 0)
      for (int k = 0; k < NHOP; k++)
        if (cvalid_m[d*NHOP+k]) begin
          lst[n] = cand_m[d*NHOP+k];
          n++;
        end
    case (r.kind)
      KIND_QUERY: begin
        if (n == 0) a.st = ST_UNKNOWN;
        else
          for (int k = 0; k < n; k++)
            if (lst[k].hop != r.hop && lst[k].s > 0) begin
              a.has = 1;
              a.nh = lst[k].hop;
              break;
            end
      end
      KIND_RESET: begin
        if (d < 0) a.st = ST_UNKNOWN;
        else begin
          dvalid_m[d] = 0;
          for (int k = 0; k < NHOP; k++) cvalid_m[d*NHOP+k] = 0;
        end
      end
      KIND_SUCCESS, KIND_FAILURE, KIND_ADD: begin
        if (d < 0)
          for (int e = 0; e < NDEST; e++)
            if (!dvalid_m[e]) begin
              d = e;
              dvalid_m[e] = 1;
              tag_m[e] = r.dest;
              for (int k = 0; k < NHOP; k++) cvalid_m[e*NHOP+k] = 0;
              break;
            end
        if (d < 0) a.st = ST_FULL;
        else begin
          at = -1;
          for (int k = 0; k < n; k++)
            if (lst[k].hop == r.hop) begin
              at = k;
              break;
            end
          if (r.kind == KIND_ADD && at >= 0) return a;
          if (at < 0) begin
            at = n;
            lst[n] = '{r.hop, 0, 0, 0};
            n++;
          end
          if (r.kind != KIND_ADD) begin
            if (r.kind == KIND_SUCCESS) begin
              if (lst[at].s < CMAX) lst[at].s++;
            end else if (lst[at].f < CMAX) lst[at].f++;
            lst[at].t = r.tms;
          end
          for (int i = 1; i < n; i++) begin
            x = lst[i];
            j = i;
            while (j > 0 && outranks(x, lst[j-1])) begin
              lst[j] = lst[j-1];
              j--;
            end
            lst[j] = x;
          end
          for (int k = 0; k < NHOP; k++) begin
            cvalid_m[d*NHOP+k] = k < n;
            if (k < n) cand_m[d*NHOP+k] = lst[k];
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk_i) in_taken <= in_valid_i && !in_stall_o;

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_q.size() > 0 && !pause_tx && (quiet || $urandom_range(99) >= 22)) begin
        in_valid_i <= 1;
        kind_i     <= pending_q[0].kind;
        dest_i     <= pending_q[0].dest;
        hop_i      <= pending_q[0].hop;
        time_ms_i  <= pending_q[0].tms;
        answer_q.push_back(table_apply(pending_q.pop_front()));
      end else in_valid_i <= 0;
    end
    out_stall_i <= hold_rx || (!quiet && $urandom_range(99) < 22);
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        $error("answer with no request outstanding");
        errors++;
      end else begin
        ans_t e;
        e = answer_q.pop_front();
        n_answers <= n_answers + 1;
        if (e.has) n_found <= n_found + 1;
        if (has_choice_o !== e.has) begin
          $error("has_choice exp %0d got %0d", e.has, has_choice_o);
          errors++;
        end
        if (next_hop_o !== e.nh) begin
          $error("next_hop exp %0d got %0d", e.nh, next_hop_o);
          errors++;
        end
        if (status_o !== e.st) begin
          $error("status exp %0d got %0d", e.st, status_o);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic req_t mk(logic [2:0] k, logic [31:0] d, logic [7:0] h, logic [31:0] t);
    req_t r;
    r = '{k, d, h, t};
    return r;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || answer_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] dpool[6];
    logic [31:0] tnow;
    logic [2:0] k;
    for (int d = 0; d < NDEST; d++) begin
      dvalid_m[d] = 0;
      tag_m[d] = 0;
    end
    for (int c = 0; c < NCAND; c++) cvalid_m[c] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // directed
    pending_q.push_back(mk(KIND_QUERY, 32'hFFFFFFFF, 8'hFF, 32'd0));
    pending_q.push_back(mk(KIND_RESET, 32'h0, 8'h00, 32'd0));
    pending_q.push_back(mk(KIND_ADD, 32'h0, 8'h00, 32'd0));
    pending_q.push_back(mk(KIND_ADD, 32'h0, 8'h00, 32'd0));
    pending_q.push_back(mk(KIND_QUERY, 32'h0, 8'h05, 32'd0));
    pending_q.push_back(mk(KIND_SUCCESS, 32'h0, 8'hFF, 32'hFFFFFFFF));
    pending_q.push_back(mk(KIND_FAILURE, 32'h0, 8'h01, 32'd5));
    pending_q.push_back(mk(KIND_SUCCESS, 32'h0, 8'h02, 32'd1));
    pending_q.push_back(mk(KIND_ADD, 32'h0, 8'h03, 32'd0));
    pending_q.push_back(mk(KIND_SUCCESS, 32'h0, 8'h04, 32'd9));
    pending_q.push_back(mk(KIND_QUERY, 32'h0, 8'hFF, 32'd0));
    pending_q.push_back(mk(KIND_QUERY, 32'h0, 8'h00, 32'd0));
    pending_q.push_back(mk(KIND_RESET, 32'h0, 8'h00, 32'd0));
    pending_q.push_back(mk(3'd5, 32'h1, 8'h1, 32'h1));
    pending_q.push_back(mk(3'd7, 32'hAAAA5555, 8'h55, 32'h5555AAAA));
    for (int i = 0; i < NDEST + 1; i++)
      pending_q.push_back(mk(KIND_ADD, 32'h100 + i, 8'(i), 32'd0));
    pending_q.push_back(mk(KIND_QUERY, 32'h110, 8'h00, 32'd0));
    drain();
    // sender waits for every answer, then clear the table
    pause_tx = 1;
    repeat (20) @(posedge clk_i);
    pause_tx = 0;
    for (int i = 0; i < NDEST; i++)
      pending_q.push_back(mk(KIND_RESET, 32'h100 + i, 8'h00, 32'd0));
    drain();

    // receiver holds off while the sender keeps offering
    hold_rx = 1;
    for (int i = 0; i < 8; i++)
      pending_q.push_back(mk(KIND_SUCCESS, 32'h7, 8'(i), 32'(i)));
    repeat (400) @(posedge clk_i);
    hold_rx = 0;
    drain();

    // random: a small pool of destinations with churn, a few hops each
    tnow = 0;
    for (int i = 0; i < 840; i++) begin
      if (i == 300 || i == 400) begin
        while (pending_q.size() > 0) @(posedge clk_i);
        quiet = (i == 300);
      end
      if (i % 150 == 0)
        foreach (dpool[j]) dpool[j] = $urandom();
      tnow = ($urandom_range(19) == 0) ? $urandom() : tnow + $urandom_range(3);
      case ($urandom_range(19))
        0, 1, 2, 3, 4: k = KIND_QUERY;
        5, 6, 7, 8, 9, 10: k = KIND_SUCCESS;
        11, 12, 13, 14: k = KIND_FAILURE;
        15: k = KIND_RESET;
        16, 17: k = KIND_ADD;
        18: k = 3'($urandom_range(7, 5));
        default: k = 3'($urandom_range(4));
      endcase
      pending_q.push_back(mk(k,
        ($urandom_range(15) == 0) ? $urandom() : dpool[$urandom_range(5)],
        ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(6)),
        tnow));
    end
    quiet = 1;
    pending_q.push_back(mk(KIND_FAILURE, 32'h5A, 8'h12, 32'd2));
    pending_q.push_back(mk(KIND_QUERY, 32'h5A, 8'h00, 32'd0));
    drain();
    repeat (100) @(posedge clk_i);
    $display("%0d answers checked, %0d queries found a hop; table fill, ranking,",
             n_answers, n_found);
    $display("overflow trimming, resets and unused kinds under input and output stalls");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/nhsr_pkg.sv
sv/nhsr_cmp.sv
sv/next_hop_success_ranker_unit.sv
dv/tb.sv
